/* src/i2c_register_access_master_top_defines.svh */
// Assertion macros shared by the I2C register-access master modules.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define I2CM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define I2CM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/i2cm_pkg.sv */
// Types, constants and helper functions of the I2C register-access master.
package i2cm_pkg;

	// Burst read geometry
	localparam int BURST_LEN = 6;
	localparam int KEPT_BYTES = 6;
	localparam logic [7:0] BURST_REG = 8'h32;

	// Queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// Segment lengths in delay units
	localparam logic [2:0] UNITS_ONE = 3'd1;
	localparam logic [2:0] UNITS_TWO = 3'd2;
	localparam logic [2:0] UNITS_FIVE = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEV_WR = 2'd0;
	localparam logic [1:0] CFG_DEV_RD = 2'd1;
	localparam logic [1:0] CFG_TICKS = 2'd2;
	localparam logic [1:0] CFG_ACK_TO = 2'd3;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_BURST = 2'd2,
		REQ_BAD   = 2'd3
	} req_kind_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_STA  = 5'd1,
		PH_STB  = 5'd2,
		PH_TXL  = 5'd3,
		PH_TXH  = 5'd4,
		PH_AKL  = 5'd5,
		PH_AKH  = 5'd6,
		PH_AKP  = 5'd7,
		PH_RSL  = 5'd8,
		PH_RXL  = 5'd9,
		PH_RXH  = 5'd10,
		PH_MAL  = 5'd11,
		PH_MAH  = 5'd12,
		PH_SPA  = 5'd13,
		PH_SPB  = 5'd14,
		PH_EPA  = 5'd15,
		PH_EPB  = 5'd16,
		PH_DONE = 5'd17,
		PH_DERR = 5'd18
	} phase_t;

	typedef struct packed {
		logic [7:0] dev_wr;
		logic [7:0] dev_rd;
		logic [7:0] ticks;
		logic [7:0] ack_to;
	} cfg_t;

	// One classified tick from the front
	typedef struct packed {
		logic       req_ok;
		req_kind_t  kind;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
		logic       sda;
	} item_t;

	typedef struct packed {
		logic        scl;
		logic        sda_drive;
		logic        sda_oe;
		logic        busy;
		logic        done;
		logic        nack_error;
		logic [7:0]  read_value;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
	} res_t;

	typedef struct packed {
		req_kind_t  kind;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
	} held_t;

	// Ticks in a segment of the given number of delay units; zero unit acts as one
	function automatic logic [10:0] seg_ticks(input logic [2:0] units, input logic [7:0] ticks);
		logic [10:0] d;
		logic [10:0] r;
		begin
			d = (ticks == 8'd0) ? 11'd1 : {3'd0, ticks};
			case (units)
				UNITS_TWO: r = d << 1;
				UNITS_FIVE: r = (d << 2) + d;
				default: r = d;
			endcase
			return r;
		end
	endfunction

endpackage

/* src/i2cm_front.sv */
// Front stage: take request ticks and classify them.
module i2cm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_valid,
	input  logic [1:0]          req_type,
	input  logic [7:0]          reg_addr,
	input  logic [7:0]          write_value,
	input  logic                sda_in,
	input  logic                push_ok,
	output logic                push,
	output i2cm_pkg::item_t     push_item
);

	logic            valid_s1;
	i2cm_pkg::item_t item_s1;
	i2cm_pkg::item_t item_d;
	logic            accept;

	// Hand the staged tick on when the queue has room
	assign push      = valid_s1 && push_ok;
	assign in_stall  = valid_s1 && !push_ok;
	assign accept    = in_valid && !in_stall;
	assign push_item = item_s1;

	// Classify: only the three known request kinds may start a transaction
	always_comb begin
		item_d.kind        = i2cm_pkg::req_kind_t'(req_type);
		item_d.req_ok      = req_valid && (item_d.kind != i2cm_pkg::REQ_BAD);
		item_d.reg_addr    = reg_addr;
		item_d.write_value = write_value;
		item_d.sda         = sda_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* src/i2cm_fifo.sv */
// Short queue between the front stage and the bus sequencer.
`include "i2c_register_access_master_top_defines.svh"

module i2cm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::item_t push_item,
	output logic            push_ok,
	input  logic            pop,
	output logic            head_valid,
	output i2cm_pkg::item_t head_item
);

	localparam int PW = $clog2(i2cm_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

	i2cm_pkg::item_t slot_q [i2cm_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	// Room when not full, or when the head leaves this cycle
	assign push_ok    = (cnt_q != CW'(i2cm_pkg::QUEUE_DEPTH)) || pop;
	assign head_valid = (cnt_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	`I2CM_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CW'(i2cm_pkg::QUEUE_DEPTH), "queue count overflow")
	`I2CM_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, cnt_q != '0, "pop from empty queue")

endmodule

/* src/i2cm_back.sv */
// Bus sequencer: one step of the I2C master per queued tick, with result register.
`include "i2c_register_access_master_top_defines.svh"

module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  i2cm_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  i2cm_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output i2cm_pkg::res_t  res
);

	i2cm_pkg::phase_t phase_q, ph;
	logic [3:0]       bit_q, bit_n;
	logic [2:0]       byte_q, byte_n;
	logic [7:0]       shift_q, shift_n;
	logic [10:0]      dly_q, dly_n;
	logic [7:0]       ack_q, ack_n;
	i2cm_pkg::held_t  held_q, held_n;
	logic [7:0]       burst_q [i2cm_pkg::KEPT_BYTES];
	logic [7:0]       burst_n [i2cm_pkg::KEPT_BYTES];
	logic             out_valid_q;
	i2cm_pkg::res_t   res_q, res_d;
	logic             fire;
	logic             last_rx;
	logic [3:0]       rx_count;
	logic [3:0]       bit_inc;

	// Step when a tick waits and the result register is free or draining
	assign fire      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = fire;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Next state and result of one tick
	always_comb begin
		ph      = phase_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		dly_n   = dly_q;
		ack_n   = ack_q;
		held_n  = held_q;
		burst_n = burst_q;
		res_d   = '0;

		// Start a transaction on a good request while idle
		if (phase_q == i2cm_pkg::PH_IDLE && head_item.req_ok) begin
			held_n.kind        = head_item.kind;
			held_n.reg_addr    = head_item.reg_addr;
			held_n.write_value = head_item.write_value;
			byte_n = '0;
			bit_n  = '0;
			ack_n  = '0;
			ph     = i2cm_pkg::PH_STA;
			dly_n  = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
		end

		rx_count = (held_n.kind == i2cm_pkg::REQ_READ) ? 4'd1 : 4'(i2cm_pkg::BURST_LEN);
		last_rx  = ({1'b0, byte_n} + 4'd1) >= rx_count;

		// Drive the bus for this tick
		res_d.scl       = 1'b1;
		res_d.sda_drive = 1'b1;
		res_d.sda_oe    = 1'b1;
		res_d.busy      = 1'b1;
		unique case (ph)
			i2cm_pkg::PH_STA, i2cm_pkg::PH_SPB, i2cm_pkg::PH_EPB: ;
			i2cm_pkg::PH_STB: res_d.sda_drive = 1'b0;
			i2cm_pkg::PH_TXL: begin
				res_d.scl       = 1'b0;
				res_d.sda_drive = shift_n[7];
			end
			i2cm_pkg::PH_TXH: res_d.sda_drive = shift_n[7];
			i2cm_pkg::PH_AKL, i2cm_pkg::PH_RXL: begin
				res_d.scl    = 1'b0;
				res_d.sda_oe = 1'b0;
			end
			i2cm_pkg::PH_AKH, i2cm_pkg::PH_AKP, i2cm_pkg::PH_RXH: res_d.sda_oe = 1'b0;
			i2cm_pkg::PH_RSL: res_d.scl = 1'b0;
			i2cm_pkg::PH_MAL: begin
				res_d.scl       = 1'b0;
				res_d.sda_drive = last_rx;
			end
			i2cm_pkg::PH_MAH: res_d.sda_drive = last_rx;
			i2cm_pkg::PH_SPA, i2cm_pkg::PH_EPA: begin
				res_d.scl       = 1'b0;
				res_d.sda_drive = 1'b0;
			end
			i2cm_pkg::PH_DONE: begin
				res_d.busy = 1'b0;
				res_d.done = 1'b1;
				if (held_n.kind == i2cm_pkg::REQ_READ) begin
					res_d.read_value = shift_n;
				end
			end
			i2cm_pkg::PH_DERR: begin
				res_d.busy       = 1'b0;
				res_d.done       = 1'b1;
				res_d.nack_error = 1'b1;
			end
			default: res_d.busy = 1'b0;
		endcase

		bit_inc = bit_n + 4'd1;

		// Advance the sequencer
		if (ph == i2cm_pkg::PH_AKP) begin
			if (!head_item.sda) begin
				// Slave acknowledged: choose what follows
				if (byte_n == 3'd0) begin
					byte_n  = 3'd1;
					shift_n = (held_n.kind == i2cm_pkg::REQ_BURST) ? i2cm_pkg::BURST_REG
						: held_n.reg_addr;
					bit_n   = '0;
					ph      = i2cm_pkg::PH_TXL;
					dly_n   = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
				end else if (byte_n == 3'd1) begin
					byte_n = 3'd2;
					if (held_n.kind == i2cm_pkg::REQ_WRITE) begin
						shift_n = held_n.write_value;
						bit_n   = '0;
						ph      = i2cm_pkg::PH_TXL;
						dly_n   = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
					end else begin
						ph    = i2cm_pkg::PH_RSL;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_ONE, cfg.ticks);
					end
				end else if (held_n.kind == i2cm_pkg::REQ_WRITE) begin
					ph    = i2cm_pkg::PH_SPA;
					dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
				end else begin
					byte_n  = '0;
					bit_n   = '0;
					shift_n = '0;
					ph      = i2cm_pkg::PH_RXL;
					dly_n   = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
				end
			end else if (ack_n >= cfg.ack_to) begin
				ph    = i2cm_pkg::PH_EPA;
				dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
			end else begin
				ack_n = ack_n + 8'd1;
			end
		end else if (ph == i2cm_pkg::PH_DONE || ph == i2cm_pkg::PH_DERR) begin
			ph = i2cm_pkg::PH_IDLE;
		end else if (ph != i2cm_pkg::PH_IDLE) begin
			if (dly_n > 11'd1) begin
				dly_n = dly_n - 11'd1;
			end else begin
				// Segment over: move to the next one
				unique case (ph)
					i2cm_pkg::PH_STA: begin
						ph    = i2cm_pkg::PH_STB;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
					end
					i2cm_pkg::PH_STB: begin
						shift_n = (byte_n == 3'd0) ? cfg.dev_wr : cfg.dev_rd;
						bit_n   = '0;
						ph      = i2cm_pkg::PH_TXL;
						dly_n   = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
					end
					i2cm_pkg::PH_TXL: begin
						ph    = i2cm_pkg::PH_TXH;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
					end
					i2cm_pkg::PH_TXH: begin
						shift_n = {shift_n[6:0], 1'b0};
						if (bit_inc >= 4'd8) begin
							bit_n = '0;
							ph    = i2cm_pkg::PH_AKL;
							dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_ONE, cfg.ticks);
						end else begin
							bit_n = bit_inc;
							ph    = i2cm_pkg::PH_TXL;
							dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
						end
					end
					i2cm_pkg::PH_AKL: begin
						ph    = i2cm_pkg::PH_AKH;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_ONE, cfg.ticks);
					end
					i2cm_pkg::PH_AKH: begin
						ack_n = '0;
						ph    = i2cm_pkg::PH_AKP;
						dly_n = '0;
					end
					i2cm_pkg::PH_RSL: begin
						ph    = i2cm_pkg::PH_STA;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
					end
					i2cm_pkg::PH_RXL: begin
						ph    = i2cm_pkg::PH_RXH;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_ONE, cfg.ticks);
					end
					i2cm_pkg::PH_RXH: begin
						shift_n = {shift_n[6:0], head_item.sda};
						if (bit_inc >= 4'd8) begin
							bit_n = '0;
							// Keep burst bytes that fit the word outputs
							if (held_n.kind == i2cm_pkg::REQ_BURST) begin
								for (int i = 0; i < i2cm_pkg::KEPT_BYTES; i++) begin
									if (byte_n == 3'(i)) begin
										burst_n[i] = shift_n;
									end
								end
							end
							ph    = i2cm_pkg::PH_MAL;
							dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
						end else begin
							bit_n = bit_inc;
							ph    = i2cm_pkg::PH_RXL;
							dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
						end
					end
					i2cm_pkg::PH_MAL: begin
						ph    = i2cm_pkg::PH_MAH;
						dly_n = i2cm_pkg::seg_ticks(last_rx ? i2cm_pkg::UNITS_TWO
							: i2cm_pkg::UNITS_FIVE, cfg.ticks);
					end
					i2cm_pkg::PH_MAH: begin
						if (last_rx) begin
							ph    = i2cm_pkg::PH_SPA;
							dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
						end else begin
							byte_n = byte_n + 3'd1;
							ph     = i2cm_pkg::PH_RXL;
							dly_n  = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_TWO, cfg.ticks);
						end
					end
					i2cm_pkg::PH_SPA: begin
						ph    = i2cm_pkg::PH_SPB;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
					end
					i2cm_pkg::PH_SPB: begin
						ph    = i2cm_pkg::PH_DONE;
						dly_n = '0;
					end
					i2cm_pkg::PH_EPA: begin
						ph    = i2cm_pkg::PH_EPB;
						dly_n = i2cm_pkg::seg_ticks(i2cm_pkg::UNITS_FIVE, cfg.ticks);
					end
					i2cm_pkg::PH_EPB: begin
						ph    = i2cm_pkg::PH_DERR;
						dly_n = '0;
					end
					default: begin
						ph    = i2cm_pkg::PH_IDLE;
						dly_n = '0;
					end
				endcase
			end
		end

		// Words are shown from the updated burst bytes
		res_d.accel_x = {burst_n[1], burst_n[0]};
		res_d.accel_y = {burst_n[3], burst_n[2]};
		res_d.accel_z = {burst_n[5], burst_n[4]};
	end

	// Commit the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			dly_q   <= '0;
			ack_q   <= '0;
			held_q  <= '0;
			for (int i = 0; i < i2cm_pkg::KEPT_BYTES; i++) begin
				burst_q[i] <= '0;
			end
		end else if (fire) begin
			phase_q <= ph;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			dly_q   <= dly_n;
			ack_q   <= ack_n;
			held_q  <= held_n;
			burst_q <= burst_n;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	`I2CM_ASSERT_NEXT(a_done_to_idle, clk, arst_n, fire && (phase_q == i2cm_pkg::PH_DONE || phase_q == i2cm_pkg::PH_DERR), phase_q == i2cm_pkg::PH_IDLE, "done tick not followed by idle")
	`I2CM_ASSERT_IMPL(a_err_on_done, clk, arst_n, out_valid_q && res_q.nack_error, res_q.done && !res_q.busy, "error flag outside done tick")
	`I2CM_ASSERT_IMPL(a_release_busy, clk, arst_n, out_valid_q && !res_q.sda_oe, res_q.busy, "SDA released outside a transaction")

endmodule

/* src/i2c_register_access_master_top.sv */
// Top level of the I2C register-access master: configuration, front, queue and sequencer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   req_valid req_type reg_addr write_value sda_in
//   out      output     out_valid / out_stall scl sda_drive sda_oe busy_res done_res
//                                             nack_error read_value accel_x accel_y accel_z
//   cfg      input      cfg_we                cfg_idx cfg_wdata
//
// One tick is taken per cycle while in_stall is low; its result passes the front register
// at acceptance, then a queue entry, then the sequencer result register before it is presented.
// The sequencer advances its full bus state by one step per tick, which sets that rate.
// Reset clears the sequencer to idle, the burst words to zero and the registers to defaults.
// A stalled output holds its result; the two-entry queue lets the input run on meanwhile.
module i2c_register_access_master_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_valid,
	input  logic [1:0]         req_type,
	input  logic [7:0]         reg_addr,
	input  logic [7:0]         write_value,
	input  logic               sda_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               scl,
	output logic               sda_drive,
	output logic               sda_oe,
	output logic               busy_res,
	output logic               done_res,
	output logic               nack_error,
	output logic [7:0]         read_value,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [7:0]         cfg_wdata
);

	i2cm_pkg::cfg_t  cfg_q;
	logic            push;
	logic            push_ok;
	logic            pop;
	logic            head_valid;
	i2cm_pkg::item_t push_item;
	i2cm_pkg::item_t head_item;
	i2cm_pkg::res_t  res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_wr <= 8'd166;
			cfg_q.dev_rd <= 8'd167;
			cfg_q.ticks  <= 8'd50;
			cfg_q.ack_to <= 8'd250;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				i2cm_pkg::CFG_DEV_WR: cfg_q.dev_wr <= cfg_wdata;
				i2cm_pkg::CFG_DEV_RD: cfg_q.dev_rd <= cfg_wdata;
				i2cm_pkg::CFG_TICKS:  cfg_q.ticks  <= cfg_wdata;
				i2cm_pkg::CFG_ACK_TO: cfg_q.ack_to <= cfg_wdata;
				default: ;
			endcase
		end
	end

	i2cm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_valid   (req_valid),
		.req_type    (req_type),
		.reg_addr    (reg_addr),
		.write_value (write_value),
		.sda_in      (sda_in),
		.push_ok     (push_ok),
		.push        (push),
		.push_item   (push_item)
	);

	i2cm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ok    (push_ok),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res        (res)
	);

	// Unpack the result
	assign scl        = res.scl;
	assign sda_drive  = res.sda_drive;
	assign sda_oe     = res.sda_oe;
	assign busy_res   = res.busy;
	assign done_res   = res.done;
	assign nack_error = res.nack_error;
	assign read_value = res.read_value;
	assign accel_x    = $signed(res.accel_x);
	assign accel_y    = $signed(res.accel_y);
	assign accel_z    = $signed(res.accel_z);

endmodule
